@@ sv/sc2a_pkg.sv @@
// Package for the scan code to ASCII decoder: key table, key kinds and modifier types.
package sc2a_pkg;

    // Number of key indexes the decoder accepts; higher indexes are dropped.
    localparam int TABLE_ENTRIES = 84;
    // Rows of the character table; indexes past it read as all-zero characters.
    localparam int ROM_ROWS = 84;

    localparam int BYTE_W = 8;
    localparam int KEY_W  = 7;

    // Bit 7 of the raw byte marks a key release.
    localparam int RELEASE_POS = 7;

    // Key indexes with a special role.
    localparam logic [KEY_W-1:0] KEY_ESC    = 7'h01;
    localparam logic [KEY_W-1:0] KEY_CTRL   = 7'h1d;
    localparam logic [KEY_W-1:0] KEY_LSHIFT = 7'h2a;
    localparam logic [KEY_W-1:0] KEY_RSHIFT = 7'h36;
    localparam logic [KEY_W-1:0] KEY_ALT    = 7'h38;
    localparam logic [KEY_W-1:0] KEY_CAPS   = 7'h3a;
    localparam logic [KEY_W-1:0] KEY_NUMLK  = 7'h45;
    localparam logic [KEY_W-1:0] KEY_SCRLK  = 7'h46;

    typedef enum logic [2:0] {
        KIND_CHAR,
        KIND_IGNORE,
        KIND_RSHIFT,
        KIND_LSHIFT,
        KIND_CTRL,
        KIND_ALT,
        KIND_CAPS
    } key_kind_t;

    // Modifier register, ordered so that the packed value matches the usual bit codes.
    typedef struct packed {
        logic alt;
        logic ctrl;
        logic caps;
        logic lshift;
        logic rshift;
    } mod_t;

    localparam mod_t MOD_NONE   = 5'h00;
    localparam mod_t MOD_RSHIFT = 5'h01;
    localparam mod_t MOD_LSHIFT = 5'h02;
    localparam mod_t MOD_CAPS   = 5'h04;
    localparam mod_t MOD_CTRL   = 5'h08;

    // One table row: plain, shifted and control characters.
    typedef struct packed {
        logic [BYTE_W-1:0] plain;
        logic [BYTE_W-1:0] shifted;
        logic [BYTE_W-1:0] ctrl;
    } key_row_t;

    // Request from the decode stage to the result register.
    typedef struct packed {
        logic              load;
        logic [BYTE_W-1:0] ascii_char;
        logic [KEY_W-1:0]  key_index;
    } res_req_t;

    localparam key_row_t CHAR_ROM [0:ROM_ROWS-1] = '{
        24'h000000, 24'h1b1b1b, 24'h312100, 24'h324000, 24'h332300, 24'h342400,
        24'h352500, 24'h365e1e, 24'h372600, 24'h382a00, 24'h392800, 24'h302900,
        24'h2d5f1f, 24'h3d2b00, 24'h08087f, 24'h090000, 24'h715111, 24'h775717,
        24'h654505, 24'h725212, 24'h745414, 24'h795919, 24'h755515, 24'h694909,
        24'h6f4f0f, 24'h705010, 24'h5b7b1b, 24'h5d7d1d, 24'h0d0d0a, 24'h000000,
        24'h614101, 24'h735313, 24'h644404, 24'h664606, 24'h674707, 24'h684808,
        24'h6a4a0a, 24'h6b4b0b, 24'h6c4c0c, 24'h3b3a00, 24'h272200, 24'h607e00,
        24'h000000, 24'h5c7c00, 24'h7a5a1a, 24'h785818, 24'h634303, 24'h765616,
        24'h624202, 24'h6e4e0e, 24'h6d4d0d, 24'h2c3c00, 24'h2e2e00, 24'h2f3f00,
        24'h000000, 24'h2a2a00, 24'h000000, 24'h202002, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h003700,
        24'hb83800, 24'hb93900, 24'h2d2d00, 24'h003400, 24'h003500, 24'h003600,
        24'h2b2b00, 24'h003100, 24'h003200, 24'hb33300, 24'h003000, 24'h002e00
    };

    // Character row for a key; rows past the table are all zero.
    function automatic key_row_t key_row(input logic [KEY_W-1:0] key);
        key_row_t row;
        row = '0;
        if (int'(key) < ROM_ROWS) begin
            row = CHAR_ROM[key];
        end
        return row;
    endfunction

    // Role of a key in the decoder.
    function automatic key_kind_t key_kind(input logic [KEY_W-1:0] key);
        key_kind_t kind;
        kind = KIND_CHAR;
        priority if (key == KEY_ESC || key == KEY_NUMLK || key == KEY_SCRLK) begin
            kind = KIND_IGNORE;
        end else if (key == KEY_RSHIFT) begin
            kind = KIND_RSHIFT;
        end else if (key == KEY_LSHIFT) begin
            kind = KIND_LSHIFT;
        end else if (key == KEY_CTRL) begin
            kind = KIND_CTRL;
        end else if (key == KEY_ALT) begin
            kind = KIND_ALT;
        end else if (key == KEY_CAPS) begin
            kind = KIND_CAPS;
        end else begin
            kind = KIND_CHAR;
        end
        return kind;
    endfunction

endpackage

@@ sv/sc2a_decode.sv @@
// Input register, modifier tracking and character selection for the decoder.
module sc2a_decode import sc2a_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_scan_byte,
    input  logic              res_free,
    output res_req_t          res_req
);

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    mod_t              mods_reg, mods_next;

    logic              release_key;
    logic [KEY_W-1:0]  key;
    logic              in_range;
    key_kind_t         kind;
    key_row_t          row;
    logic              emit;
    logic              advance;
    logic [BYTE_W-1:0] char_sel;

    // Split the held byte and look the key up.
    always_comb begin
        release_key = in_byte_reg[RELEASE_POS];
        key         = in_byte_reg[KEY_W-1:0];
        in_range    = int'(key) < TABLE_ENTRIES;
        kind        = key_kind(key);
        row         = key_row(key);
    end

    // A press of an ordinary key in range produces a result; anything else just drains.
    assign emit    = in_valid_reg && in_range && (kind == KIND_CHAR) && !release_key;
    assign advance = in_valid_reg && (!emit || res_free);
    assign s_ready = !in_valid_reg || advance;

    // Pick the column from the modifier state seen before this key.
    always_comb begin
        unique case (mods_reg)
            MOD_RSHIFT, MOD_LSHIFT, MOD_CAPS: char_sel = row.shifted;
            MOD_CTRL:                         char_sel = row.ctrl;
            MOD_NONE:                         char_sel = row.plain;
            default:                          char_sel = '0;
        endcase
    end

    always_comb begin
        res_req.load       = emit && res_free;
        res_req.ascii_char = char_sel;
        res_req.key_index  = key;
    end

    // Modifier updates take effect when the request leaves the input register.
    always_comb begin
        mods_next = mods_reg;
        if (advance && in_range) begin
            unique case (kind)
                KIND_RSHIFT: mods_next.rshift = !release_key;
                KIND_LSHIFT: mods_next.lshift = !release_key;
                KIND_CTRL:   mods_next.ctrl   = !release_key;
                KIND_ALT:    mods_next.alt    = !release_key;
                KIND_CAPS: begin
                    if (!release_key) begin
                        mods_next.caps = !mods_reg.caps;
                    end
                end
                KIND_IGNORE, KIND_CHAR: mods_next = mods_reg;
                default: mods_next = mods_reg;
            endcase
        end
    end

    // Input register occupancy.
    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mods_reg     <= MOD_NONE;
        end else begin
            in_valid_reg <= in_valid_next;
            mods_reg     <= mods_next;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_scan_byte;
        end
    end

endmodule

@@ sv/sc2a_out_reg.sv @@
// Result register that holds one character request until the consumer takes it.
module sc2a_out_reg import sc2a_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  res_req_t          res_req,
    output logic              res_free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_ascii_char,
    output logic [KEY_W-1:0]  m_key_index
);

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] char_reg;
    logic [KEY_W-1:0]  key_reg;

    // The register can take a new request when empty or being drained this cycle.
    assign res_free = !valid_reg || m_ready;

    always_comb begin
        if (res_req.load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_req.load) begin
            char_reg <= res_req.ascii_char;
            key_reg  <= res_req.key_index;
        end
    end

    assign m_valid      = valid_reg;
    assign m_ascii_char = char_reg;
    assign m_key_index  = key_reg;

endmodule

@@ sv/scancode_to_ascii_decoder_unit.sv @@
// Top level of the scan code set 1 to ASCII decoder.
// Each request is one raw keyboard byte (bit 7 set for a release). The byte is
// held in an input register. After table lookup and modifier logic on the held
// byte, a key press loads a character request into the result register, which
// then offers the result to the consumer on m_valid. A new byte is accepted every
// cycle as long as the result side keeps up; while a result waits, one byte
// stays in the input register and the input stalls. Shift, control, alt and caps
// lock update the modifier state and produce no result; key releases, escape,
// num lock, scroll lock and key indexes of 0x54 and above (the 0xE0 prefix
// included) produce nothing. With alt or two modifiers held the character is 0.
module scancode_to_ascii_decoder_unit import sc2a_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_scan_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_ascii_char,
    output logic [KEY_W-1:0]  m_key_index
);

    res_req_t res_req;
    logic     res_free;

    // Lookup and modifier stage.
    sc2a_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_scan_byte (s_scan_byte),
        .res_free    (res_free),
        .res_req     (res_req)
    );

    // Result register toward the consumer.
    sc2a_out_reg u_out_reg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .res_req      (res_req),
        .res_free     (res_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ascii_char (m_ascii_char),
        .m_key_index  (m_key_index)
    );

endmodule

@@ sv/sc2a_checker.sv @@
// Port-level checks for the scan code decoder, bound to the top level.
module sc2a_checker import sc2a_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [BYTE_W-1:0] s_scan_byte,
    input logic              m_valid,
    input logic              m_ready,
    input logic [BYTE_W-1:0] m_ascii_char,
    input logic [KEY_W-1:0]  m_key_index
);

    // The result register comes out of reset empty.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ascii_char) && $stable(m_key_index))
        else $error("stalled result changed");

    // Only keys inside the table produce results.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> int'(m_key_index) < TABLE_ENTRIES)
        else $error("result for key outside table");

    // Modifier and ignored keys never produce a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_key_index != KEY_ESC && m_key_index != KEY_NUMLK
            && m_key_index != KEY_SCRLK && m_key_index != KEY_RSHIFT
            && m_key_index != KEY_LSHIFT && m_key_index != KEY_CTRL
            && m_key_index != KEY_ALT && m_key_index != KEY_CAPS)
        else $error("result for modifier or ignored key");

    // With no result pending and no byte accepted now or at the last sample, no result can appear next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !(s_valid && s_ready) && $past(!(s_valid && s_ready)) |=> !m_valid)
        else $error("result without a request");

endmodule

bind scancode_to_ascii_decoder_unit sc2a_checker u_sc2a_checker (.*);
